/* rtl/core/dtk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dtk_pkg;

	// Operation codes carried on the action field
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DROP   = 2'd1,
		ACT_READ   = 2'd2
	} action_t;

	// Per-cell control broadcast from the list controller
	typedef struct packed {
		logic insert;     // insert transaction accepted this cycle
		logic past_count; // cell position is at or beyond the held count
	} dtk_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/descending_top_k_list.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted transaction's result is on the output register from the next cycle on.
// Throughput: one transaction per cycle; every cell compares against the new key in
// parallel and shifts one place in the same cycle. The output register refills in the
// cycle its transaction leaves; while a result waits unaccepted, the input stalls.
// Reset (arst_n low, asynchronous): list empties (count 0) and no result is pending;
// cell contents are left as they are and are never read before being written.
module descending_top_k_list #(
	parameter int CAPACITY     = 16,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 32,
	localparam int POS_W       = $clog2(CAPACITY),
	localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire        [1:0]              action,
	input  wire signed [KEY_BITS-1:0]     new_key,
	input  wire        [PAYLOAD_BITS-1:0] new_payload,
	input  wire        [POS_W-1:0]        read_position,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic                          entry_valid,
	output logic signed [KEY_BITS-1:0]    entry_key,
	output logic       [PAYLOAD_BITS-1:0] entry_payload,
	output logic       [CNT_W-1:0]        entry_count,
	output logic                          overflow_drop
);
	import dtk_pkg::*;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	logic                          in_fire;
	logic [CNT_W-1:0]              count_q, count_d;
	logic                          out_valid_q;
	logic                          entry_valid_q, entry_valid_d;
	logic signed [KEY_BITS-1:0]    entry_key_q, entry_key_d;
	logic [PAYLOAD_BITS-1:0]       entry_payload_q, entry_payload_d;
	logic                          overflow_q, overflow_d;
	logic [CNT_W-1:0]              last_pos, read_clamped;
	logic [POS_W-1:0]              read_idx;

	logic                          here_w    [CAPACITY];
	logic signed [KEY_BITS-1:0]    key_w     [CAPACITY];
	logic [PAYLOAD_BITS-1:0]       payload_w [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		dtk_ctrl_t ctrl;
		assign ctrl.insert     = in_fire && (action == ACT_INSERT);
		assign ctrl.past_count = (CNT_W'(i) >= count_q);
		if (i == 0) begin : g_head
			dtk_cell #(
				.KEY_BITS     (KEY_BITS),
				.PAYLOAD_BITS (PAYLOAD_BITS)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl),
				.new_key      (new_key),
				.new_payload  (new_payload),
				.prev_here    (1'b0),
				.prev_key     (new_key),
				.prev_payload (new_payload),
				.here         (here_w[i]),
				.key          (key_w[i]),
				.payload      (payload_w[i])
			);
		end else begin : g_body
			dtk_cell #(
				.KEY_BITS     (KEY_BITS),
				.PAYLOAD_BITS (PAYLOAD_BITS)
			) u_cell (
				.clk          (clk),
				.ctrl         (ctrl),
				.new_key      (new_key),
				.new_payload  (new_payload),
				.prev_here    (here_w[i-1]),
				.prev_key     (key_w[i-1]),
				.prev_payload (payload_w[i-1]),
				.here         (here_w[i]),
				.key          (key_w[i]),
				.payload      (payload_w[i])
			);
		end
	end

	// Clamp the read position to the tail entry
	assign last_pos     = count_q - CNT_W'(1);
	assign read_clamped = (CNT_W'(read_position) > last_pos) ? last_pos : CNT_W'(read_position);
	assign read_idx     = read_clamped[POS_W-1:0];

	always_comb begin
		count_d         = count_q;
		entry_valid_d   = 1'b0;
		entry_key_d     = '0;
		entry_payload_d = '0;
		overflow_d      = 1'b0;
		case (action)
			ACT_INSERT: begin
				if (count_q == CNT_FULL) begin
					overflow_d = 1'b1;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_DROP: begin
				if (count_q != '0) begin
					count_d = count_q - CNT_W'(1);
				end
			end
			ACT_READ: begin
				if (count_q != '0) begin
					entry_valid_d   = 1'b1;
					entry_key_d     = key_w[read_idx];
					entry_payload_d = payload_w[read_idx];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			entry_valid_q   <= entry_valid_d;
			entry_key_q     <= entry_key_d;
			entry_payload_q <= entry_payload_d;
			overflow_q      <= overflow_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign entry_valid   = entry_valid_q;
	assign entry_key     = entry_key_q;
	assign entry_payload = entry_payload_q;
	assign entry_count   = count_q;
	assign overflow_drop = overflow_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("held count exceeds capacity");

	a_read_hit: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (action == ACT_READ) && (count_q != '0) |=> out_valid && entry_valid)
		else $error("read of non-empty list returned no entry");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (count_q != CNT_FULL) |=> !overflow_drop)
		else $error("overflow reported on a list that was not full");

	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (action == ACT_DROP) && (count_q == '0) |=> count_q == '0)
		else $error("drop on empty list changed the count");
`endif

endmodule

`default_nettype wire

/* rtl/core/dtk_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module dtk_cell #(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                           clk,
	input  dtk_pkg::dtk_ctrl_t            ctrl,
	input  wire signed [KEY_BITS-1:0]     new_key,
	input  wire        [PAYLOAD_BITS-1:0] new_payload,
	input  wire                           prev_here,
	input  wire signed [KEY_BITS-1:0]     prev_key,
	input  wire        [PAYLOAD_BITS-1:0] prev_payload,
	output logic                          here,
	output logic signed [KEY_BITS-1:0]    key,
	output logic       [PAYLOAD_BITS-1:0] payload
);
	import dtk_pkg::*;

	logic signed [KEY_BITS-1:0]     key_q;
	logic        [PAYLOAD_BITS-1:0] payload_q;

	// Insert point lies at or before this cell: new key ranks ahead of equal or smaller keys
	assign here    = ctrl.past_count || (key_q <= new_key);
	assign key     = key_q;
	assign payload = payload_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (prev_here) begin
				// shift back from the neighbour ahead
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end else if (here) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end
		end
	end

endmodule

`default_nettype wire

/* tb/descending_top_k_list_tb.sv */
`timescale 1ns / 1ps

module descending_top_k_list_tb;
	import dtk_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN
	} mix_bias_t;

	typedef struct packed {
		logic        found;
		logic [31:0] key;
		logic [31:0] payload;
		logic [4:0]  count;
		logic        dropped;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic signed [31:0] new_key;
	logic [31:0]        new_payload;
	logic [3:0]         read_position;
	logic               out_valid;
	logic               out_ready;
	logic               entry_valid;
	logic signed [31:0] entry_key;
	logic [31:0]        entry_payload;
	logic [4:0]         entry_count;
	logic               overflow_drop;

	// shadow copy of the list
	logic signed [31:0] shadow_key [LIST_DEPTH];
	logic [31:0]        shadow_payload [LIST_DEPTH];
	int                 shadow_len;

	list_result_t pending_results[$];
	int           err_count;
	int           cycle_count;
	logic         idle_on;
	logic         hold_req;

	descending_top_k_list dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.new_key       (new_key),
		.new_payload   (new_payload),
		.read_position (read_position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_valid   (entry_valid),
		.entry_key     (entry_key),
		.entry_payload (entry_payload),
		.entry_count   (entry_count),
		.overflow_drop (overflow_drop)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one operation to the shadow list and return the result it yields
	function automatic list_result_t step_shadow_list(logic [1:0] act, logic signed [31:0] key,
			logic [31:0] payload, logic [3:0] pos);
		list_result_t r;
		int at;
		int top;
		int p;
		r = '0;
		case (act)
			ACT_INSERT: begin
				at = 0;
				while (at < shadow_len && shadow_key[at] > key)
					at++;
				r.dropped = (shadow_len == LIST_DEPTH);
				if (at < LIST_DEPTH) begin
					top = (shadow_len < LIST_DEPTH) ? shadow_len : LIST_DEPTH - 1;
					for (int i = top; i > at; i--) begin
						shadow_key[i] = shadow_key[i-1];
						shadow_payload[i] = shadow_payload[i-1];
					end
					shadow_key[at] = key;
					shadow_payload[at] = payload;
				end
				if (shadow_len < LIST_DEPTH)
					shadow_len++;
			end
			ACT_DROP: begin
				if (shadow_len > 0)
					shadow_len--;
			end
			ACT_READ: begin
				if (shadow_len > 0) begin
					p = (pos > shadow_len - 1) ? shadow_len - 1 : pos;
					r.found = 1'b1;
					r.key = shadow_key[p];
					r.payload = shadow_payload[p];
				end
			end
			default: ;
		endcase
		r.count = shadow_len[4:0];
		return r;
	endfunction

	task automatic send_item(logic [1:0] act, logic signed [31:0] key, logic [31:0] payload,
			logic [3:0] pos);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		new_key = key;
		new_payload = payload;
		read_position = pos;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(step_shadow_list(act, key, payload, pos));
	endtask

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return KEY_MAX;
			1: return KEY_MIN;
			2, 3, 4: return $signed($urandom_range(0, 7)) - 4; // few values, many ties
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_payload();
		case ($urandom_range(0, 15))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_item(mix_bias_t bias);
		int roll;
		logic [1:0] act;
		roll = $urandom_range(0, 99);
		if (bias == MIX_FILL)
			act = (roll < 65) ? ACT_INSERT : (roll < 80) ? ACT_READ :
				(roll < 97) ? ACT_DROP : ACT_UNUSED;
		else
			act = (roll < 25) ? ACT_INSERT : (roll < 45) ? ACT_READ :
				(roll < 97) ? ACT_DROP : ACT_UNUSED;
		send_item(act, pick_key(), pick_payload(), 4'($urandom_range(0, 15)));
	endtask

	task automatic test_empty_list();
		send_item(ACT_READ, 32'sd0, 32'h0, 4'd0);
		send_item(ACT_DROP, KEY_MAX, 32'hffff_ffff, 4'd15);
		send_item(ACT_UNUSED, KEY_MIN, 32'h5555_aaaa, 4'd7);
	endtask

	task automatic test_extremes_and_ties();
		send_item(ACT_INSERT, KEY_MAX, 32'hffff_ffff, 4'd0);
		send_item(ACT_INSERT, KEY_MIN, 32'h0, 4'd0);
		send_item(ACT_INSERT, 32'sd0, 32'haaaa_5555, 4'd0);
		// equal key: the newer entry goes ahead
		send_item(ACT_INSERT, 32'sd0, 32'h1234_5678, 4'd0);
		send_item(ACT_READ, 32'sd0, 32'h0, 4'd15);
		send_item(ACT_READ, 32'sd0, 32'h0, 4'd1);
		send_item(ACT_DROP, 32'sd0, 32'h0, 4'd0);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < 13; i++)
			send_item(ACT_INSERT, 32'sd1000 - 7 * i, 32'(i), 4'd0);
		// full list: lowest-ranking newcomer is dropped, then a mid-ranking one evicts the tail
		send_item(ACT_INSERT, KEY_MIN, 32'hdead_beef, 4'd0);
		send_item(ACT_INSERT, 32'sd500, 32'hcafe_f00d, 4'd0);
		send_item(ACT_READ, 32'sd0, 32'h0, 4'd15);
	endtask

	task automatic test_output_stall();
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_random_item(MIX_FILL);
	endtask

	task automatic test_random_mix(int n_items);
		int sent;
		int chunk;
		mix_bias_t bias;
		sent = 0;
		bias = MIX_FILL;
		while (sent < n_items) begin
			chunk = $urandom_range(20, 80);
			for (int i = 0; i < chunk && sent < n_items; i++) begin
				send_random_item(bias);
				sent++;
			end
			bias = (bias == MIX_FILL) ? MIX_DRAIN : MIX_FILL;
		end
	endtask

	task automatic test_streaming(int n_items);
		idle_on = 1'b0;
		for (int i = 0; i < n_items; i++)
			send_random_item((i / 40) % 2 == 0 ? MIX_FILL : MIX_DRAIN);
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready = 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with none outstanding");
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (entry_valid !== want.found) begin
					$error("entry_valid: expected %0d, got %0d", want.found, entry_valid);
					err_count++;
				end
				if (entry_key !== $signed(want.key)) begin
					$error("entry_key: expected %0d, got %0d", $signed(want.key), entry_key);
					err_count++;
				end
				if (entry_payload !== want.payload) begin
					$error("entry_payload: expected %h, got %h", want.payload, entry_payload);
					err_count++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					err_count++;
				end
				if (overflow_drop !== want.dropped) begin
					$error("overflow_drop: expected %0d, got %0d", want.dropped, overflow_drop);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_INSERT;
		new_key = '0;
		new_payload = '0;
		read_position = '0;
		err_count = 0;
		cycle_count = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		shadow_len = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_extremes_and_ties();
		test_overflow();
		test_output_stall();
		test_random_mix(1030);
		test_streaming(150);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/dtk_pkg.sv
rtl/core/dtk_cell.sv
rtl/core/descending_top_k_list.sv
tb/descending_top_k_list_tb.sv
